// File: rtl/bsrm_pkg.sv
// Shared types and constants of the backing store region map.
package bsrm_pkg;

  localparam int unsigned PID_W   = 7;
  localparam int unsigned PAGE_W  = 20;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned STORE_W = 3;
  localparam int unsigned KIND_W  = 2;

  // One table word: owner, base page, page count.
  localparam int unsigned WORD_W = PID_W + PAGE_W + COUNT_W;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_MARK   = 2'd3
  } req_kind_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // register the incoming request
    logic issue;     // read the next table slot
    logic exec;      // perform an add or mark in place
    logic out_load;  // copy the result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_kind;    // request walks the table (lookup or remove)
    logic last_issued;  // read pointer sits on the last slot
    logic hit;          // lookup found its slot
  } sts_t;

endpackage

// File: rtl/bsrm_if.sv
// Request and response channel interfaces of the region map.
interface bsrm_req_if
  import bsrm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    req_type;
  logic [PID_W-1:0]     proc_id;
  logic [PAGE_W-1:0]    page_num;
  logic [COUNT_W-1:0]   page_count;
  logic [STORE_W-1:0]   store_id;

  modport source (output valid, req_type, proc_id, page_num, page_count, store_id,
                  input ready);
  modport sink   (input valid, req_type, proc_id, page_num, page_count, store_id,
                  output ready);
endinterface

interface bsrm_rsp_if
  import bsrm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 status;
  logic [STORE_W-1:0]   hit_store;
  logic [PAGE_W-1:0]    hit_base_page;
  logic [COUNT_W-1:0]   hit_page_count;

  modport source (output valid, status, hit_store, hit_base_page, hit_page_count,
                  input ready);
  modport sink   (input valid, status, hit_store, hit_base_page, hit_page_count,
                  output ready);
endinterface

// File: rtl/backing_store_region_map_top.sv
// Top level of the backing store region map: sequencer plus datapath.
//
// A table with one mapping slot per backing store. Each request beat on req_i
// yields exactly one response beat on rsp_o, in order. A lookup walks the
// slots from 0 upward, reading one slot per cycle from the slot RAM, and
// returns the lowest slot whose store is in use, whose mapping is valid,
// whose owner equals proc_id and whose range base <= page < base + count
// (a zero-page mapping never matches); the walk stops at the first hit. A
// remove walks every slot and drops each mapping of the process together with
// its store. Add and mark act on the slot named by store_id in one step.
// A walk reads the slots one at a time through the single read port of the
// slot RAM. One request is in work at a time; a new request is accepted
// while the previous response still waits in the output register, and the
// block holds off further requests until that register frees up. No
// clearing pass is needed after reset.
module backing_store_region_map_top
  import bsrm_pkg::*;
#(
  parameter int unsigned ENTRIES = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bsrm_req_if.sink   req_i,
  bsrm_rsp_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: owns both handshakes and the response valid flag.
  bsrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: captures the request beat, holds the table, drives the payload.
  bsrm_dp #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_i.req_type),
    .proc_id_i       (req_i.proc_id),
    .page_num_i      (req_i.page_num),
    .page_count_i    (req_i.page_count),
    .store_id_i      (req_i.store_id),
    .status_o        (rsp_o.status),
    .hit_store_o     (rsp_o.hit_store),
    .hit_base_page_o (rsp_o.hit_base_page),
    .hit_page_count_o(rsp_o.hit_page_count)
  );

endmodule

// File: rtl/bsrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bsrm_ctrl.sv
// Sequencer of the region map: handshakes, table walk and result hand-off.
module bsrm_ctrl
  import bsrm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!sts_i.scan_kind) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_FINISH;
        end else if (sts_i.hit) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.issue = 1'b1;
          if (sts_i.last_issued) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // last slot compares in this cycle
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/bsrm_dp.sv
// Datapath of the region map: request registers, slot table and compare.
module bsrm_dp
  import bsrm_pkg::*;
#(
  parameter int unsigned ENTRIES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [KIND_W-1:0]  req_type_i,
  input  logic [PID_W-1:0]   proc_id_i,
  input  logic [PAGE_W-1:0]  page_num_i,
  input  logic [COUNT_W-1:0] page_count_i,
  input  logic [STORE_W-1:0] store_id_i,
  output logic               status_o,
  output logic [STORE_W-1:0] hit_store_o,
  output logic [PAGE_W-1:0]  hit_base_page_o,
  output logic [COUNT_W-1:0] hit_page_count_o
);

  localparam int unsigned AW = $clog2(ENTRIES);

  req_kind_e          kind_q;
  logic [PID_W-1:0]   pid_q;
  logic [PAGE_W-1:0]  page_q;
  logic [COUNT_W-1:0] count_q;
  logic [STORE_W-1:0] sid_q;

  logic [ENTRIES-1:0] map_valid_q;
  logic [ENTRIES-1:0] in_use_q;

  logic [AW-1:0] rd_idx_q;
  logic [AW-1:0] cmp_idx_q;
  logic          rd_vld_q;
  logic          hit_q;

  logic               res_status_q;
  logic [STORE_W-1:0] res_store_q;
  logic [PAGE_W-1:0]  res_base_q;
  logic [COUNT_W-1:0] res_count_q;

  logic               out_status_q;
  logic [STORE_W-1:0] out_store_q;
  logic [PAGE_W-1:0]  out_base_q;
  logic [COUNT_W-1:0] out_count_q;

  logic [WORD_W-1:0]  rdata;
  logic [PID_W-1:0]   rd_owner;
  logic [PAGE_W-1:0]  rd_base;
  logic [COUNT_W-1:0] rd_pages;
  logic [PAGE_W:0]    rd_end;
  logic               owner_match;
  logic               range_ok;
  logic               lookup_hit;
  logic               remove_hit;

  logic          sid_ok;
  logic [AW-1:0] slot;
  logic          add_ok;
  logic          mark_ok;

  assign {rd_owner, rd_base, rd_pages} = rdata;
  assign rd_end      = (PAGE_W+1)'(rd_base) + (PAGE_W+1)'(rd_pages);
  assign owner_match = map_valid_q[cmp_idx_q] && (rd_owner == pid_q);
  // empty range never matches: end equals base
  assign range_ok    = (page_q >= rd_base) && ((PAGE_W+1)'(page_q) < rd_end);
  assign lookup_hit  = rd_vld_q && (kind_q == REQ_LOOKUP) && !hit_q &&
                       in_use_q[cmp_idx_q] && owner_match && range_ok;
  assign remove_hit  = rd_vld_q && (kind_q == REQ_REMOVE) && owner_match;

  assign sid_ok  = 32'(sid_q) < ENTRIES;
  assign slot    = AW'(sid_q);
  assign add_ok  = sid_ok && in_use_q[slot] && !map_valid_q[slot];
  assign mark_ok = sid_ok && !in_use_q[slot];

  bsrm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.exec && (kind_q == REQ_ADD) && add_ok),
    .waddr_i(slot),
    .wdata_i({pid_q, page_q, count_q}),
    .raddr_i(rd_idx_q),
    .rdata_o(rdata)
  );

  // Control state: table flags and the walk pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_valid_q <= '0;
      in_use_q    <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.capture) begin
        rd_idx_q <= '0;
        hit_q    <= 1'b0;
      end else if (cmd_i.issue) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (lookup_hit) begin
        hit_q <= 1'b1;
      end
      if (remove_hit) begin
        map_valid_q[cmp_idx_q] <= 1'b0;
        in_use_q[cmp_idx_q]    <= 1'b0;
      end
      if (cmd_i.exec && (kind_q == REQ_ADD) && add_ok) begin
        map_valid_q[slot] <= 1'b1;
      end
      if (cmd_i.exec && (kind_q == REQ_MARK) && mark_ok) begin
        in_use_q[slot] <= 1'b1;
      end
    end
  end

  // Payload: request, result and output registers.
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= rd_idx_q;
    if (cmd_i.capture) begin
      kind_q       <= req_kind_e'(req_type_i);
      pid_q        <= proc_id_i;
      page_q       <= page_num_i;
      count_q      <= page_count_i;
      sid_q        <= store_id_i;
      res_status_q <= (req_kind_e'(req_type_i) == REQ_REMOVE) ? STATUS_OK : STATUS_ERR;
      res_store_q  <= '0;
      res_base_q   <= '0;
      res_count_q  <= '0;
    end
    if (lookup_hit) begin
      res_status_q <= STATUS_OK;
      res_store_q  <= STORE_W'(cmp_idx_q);
      res_base_q   <= rd_base;
      res_count_q  <= rd_pages;
    end
    if (cmd_i.exec) begin
      res_status_q <= ((kind_q == REQ_ADD) ? add_ok : mark_ok) ? STATUS_OK : STATUS_ERR;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_store_q  <= res_store_q;
      out_base_q   <= res_base_q;
      out_count_q  <= res_count_q;
    end
  end

  assign sts_o.scan_kind   = (kind_q == REQ_LOOKUP) || (kind_q == REQ_REMOVE);
  assign sts_o.last_issued = (rd_idx_q == AW'(ENTRIES - 1));
  assign sts_o.hit         = hit_q;

  assign status_o         = out_status_q;
  assign hit_store_o      = out_store_q;
  assign hit_base_page_o  = out_base_q;
  assign hit_page_count_o = out_count_q;

endmodule

// File: rtl/bsrm_checker.sv
// Port-level checks of the region map, bound to the top level.
module bsrm_checker
  import bsrm_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic               rsp_status_i,
  input logic [STORE_W-1:0] rsp_store_i,
  input logic [PAGE_W-1:0]  rsp_base_i,
  input logic [COUNT_W-1:0] rsp_count_i
);

  logic       req_beat;
  logic       rsp_beat;
  logic [1:0] pend_q;

  assign req_beat = req_valid_i && req_ready_i;
  assign rsp_beat = rsp_valid_i && rsp_ready_i;

  // Count requests accepted but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(req_beat) - 2'(rsp_beat);
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response valid dropped before the beat");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_status_i) && $stable(rsp_store_i) &&
      $stable(rsp_base_i) && $stable(rsp_count_i))
    else $error("response payload changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 2'd0)
    else $error("response offered with no request outstanding");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two requests outstanding");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == STATUS_ERR) |->
      (rsp_store_i == '0) && (rsp_base_i == '0) && (rsp_count_i == '0))
    else $error("error response carries hit fields");

endmodule

bind backing_store_region_map_top bsrm_checker u_bsrm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_status_i(rsp_o.status),
  .rsp_store_i (rsp_o.hit_store),
  .rsp_base_i  (rsp_o.hit_base_page),
  .rsp_count_i (rsp_o.hit_page_count)
);

// File: test/backing_store_region_map_top_tb.sv
// Self-checking testbench of the backing store region map: directed table plus random traffic.
`timescale 1ns / 1ps

module backing_store_region_map_top_tb;
  import bsrm_pkg::*;

  localparam int unsigned ENTRIES = 8;
  localparam int unsigned DIR_N   = 25;
  localparam int unsigned RAND_N  = 625;

  // One request beat and one response beat, at the widths of the ports.
  typedef struct packed {
    req_kind_e            kind;
    logic [PID_W-1:0]     pid;
    logic [PAGE_W-1:0]    page;
    logic [COUNT_W-1:0]   count;
    logic [STORE_W-1:0]   sid;
  } req_beat_t;

  typedef struct packed {
    logic                 status;
    logic [STORE_W-1:0]   store;
    logic [PAGE_W-1:0]    base;
    logic [COUNT_W-1:0]   pages;
  } rsp_beat_t;

  // A directed row: the request, and a typed-in response where 'fixed' is set.
  typedef struct packed {
    req_beat_t            req;
    logic                 fixed;
    rsp_beat_t            rsp;
  } dir_row_t;

  // What the driver hands the monitor for each beat it offers.
  typedef struct packed {
    logic                 fixed;
    rsp_beat_t            rsp;
  } rsp_hint_t;

  localparam rsp_beat_t RSP_OK   = '{STATUS_OK,  3'd0, 20'd0, 10'd0};
  localparam rsp_beat_t RSP_FAIL = '{STATUS_ERR, 3'd0, 20'd0, 10'd0};

  // Directed part. Rows with fixed = 0 are checked against the predictor only.
  localparam dir_row_t DIR_TBL [DIR_N] = '{
    // empty table: lookup misses, add to a free store fails, remove of nothing passes
    '{'{REQ_LOOKUP, 7'd0,   20'h00000, 10'd0,    3'd0}, 1'b1, RSP_FAIL},
    '{'{REQ_ADD,    7'd1,   20'h12345, 10'd5,    3'd0}, 1'b1, RSP_FAIL},
    '{'{REQ_REMOVE, 7'd5,   20'h00000, 10'd0,    3'd0}, 1'b1, RSP_OK},
    // mark, then mark again on a store already in use
    '{'{REQ_MARK,   7'd0,   20'h00000, 10'd0,    3'd0}, 1'b1, RSP_OK},
    '{'{REQ_MARK,   7'd0,   20'h00000, 10'd0,    3'd0}, 1'b1, RSP_FAIL},
    '{'{REQ_MARK,   7'd0,   20'h00000, 10'd0,    3'd7}, 1'b1, RSP_OK},
    // top of the page space with the widest range; a second add on the taken slot
    '{'{REQ_ADD,    7'd127, 20'hFFFFF, 10'd1023, 3'd0}, 1'b1, RSP_OK},
    '{'{REQ_ADD,    7'd1,   20'h00000, 10'd1,    3'd0}, 1'b1, RSP_FAIL},
    '{'{REQ_LOOKUP, 7'd127, 20'hFFFFF, 10'd0,    3'd0}, 1'b1,
      '{STATUS_OK, 3'd0, 20'hFFFFF, 10'd1023}},
    '{'{REQ_LOOKUP, 7'd127, 20'hFFFFE, 10'd0,    3'd0}, 1'b1, RSP_FAIL},
    '{'{REQ_LOOKUP, 7'd1,   20'hFFFFF, 10'd0,    3'd0}, 1'b1, RSP_FAIL},
    // zero-page mapping never matches
    '{'{REQ_MARK,   7'd0,   20'h00000, 10'd0,    3'd3}, 1'b1, RSP_OK},
    '{'{REQ_ADD,    7'd127, 20'h00000, 10'd0,    3'd3}, 1'b1, RSP_OK},
    '{'{REQ_LOOKUP, 7'd127, 20'h00000, 10'd0,    3'd0}, 1'b1, RSP_FAIL},
    // range edges at the bottom of the page space
    '{'{REQ_ADD,    7'd127, 20'h00000, 10'd1023, 3'd7}, 1'b1, RSP_OK},
    '{'{REQ_LOOKUP, 7'd127, 20'h003FE, 10'd0,    3'd0}, 1'b1,
      '{STATUS_OK, 3'd7, 20'h00000, 10'd1023}},
    '{'{REQ_LOOKUP, 7'd127, 20'h003FF, 10'd0,    3'd0}, 1'b1, RSP_FAIL},
    // overlapping ranges: the lowest slot wins
    '{'{REQ_MARK,   7'd0,   20'h00000, 10'd0,    3'd5}, 1'b1, RSP_OK},
    '{'{REQ_ADD,    7'd127, 20'h00002, 10'd10,   3'd5}, 1'b1, RSP_OK},
    '{'{REQ_LOOKUP, 7'd127, 20'h00005, 10'd0,    3'd0}, 1'b0, RSP_OK},
    // process exit frees every store behind it
    '{'{REQ_REMOVE, 7'd127, 20'h00000, 10'd0,    3'd0}, 1'b1, RSP_OK},
    '{'{REQ_LOOKUP, 7'd127, 20'h00005, 10'd0,    3'd0}, 1'b1, RSP_FAIL},
    '{'{REQ_ADD,    7'd127, 20'h00000, 10'd4,    3'd7}, 1'b1, RSP_FAIL},
    '{'{REQ_MARK,   7'd0,   20'h00000, 10'd0,    3'd7}, 1'b1, RSP_OK},
    '{'{REQ_LOOKUP, 7'd85,  20'hAAAAA, 10'h2AA,  3'd2}, 1'b0, RSP_OK}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   quiet;          // high while neither side may idle
  int   mismatch_cnt;

  // Predictor copy of the slot table.
  bit                 tbl_valid  [ENTRIES];
  bit                 store_busy [ENTRIES];
  logic [PID_W-1:0]   tbl_owner  [ENTRIES];
  logic [PAGE_W-1:0]  tbl_base   [ENTRIES];
  logic [COUNT_W-1:0] tbl_pages  [ENTRIES];

  rsp_hint_t hint_q [$];        // one entry per beat offered, in order
  rsp_beat_t pending_rsp_q [$]; // responses owed by the block, oldest first

  bsrm_req_if req_bus ();
  bsrm_rsp_if rsp_bus ();

  backing_store_region_map_top #(
    .ENTRIES (ENTRIES)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one accepted request to the table copy and return the response it owes.
  function automatic rsp_beat_t region_map_apply(req_beat_t r);
    rsp_beat_t    res;
    int unsigned  lim;
    bit           found;
    res   = RSP_FAIL;
    found = 1'b0;
    case (r.kind)
      REQ_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          // widen before the add so the range end never wraps
          lim = int'(tbl_base[i]) + int'(tbl_pages[i]);
          if (!found && store_busy[i] && tbl_valid[i] && tbl_owner[i] == r.pid &&
              r.page >= tbl_base[i] && int'(r.page) < lim) begin
            found  = 1'b1;
            res    = '{STATUS_OK, STORE_W'(i), tbl_base[i], tbl_pages[i]};
          end
        end
      end
      REQ_ADD: begin
        if (r.sid < ENTRIES && store_busy[r.sid] && !tbl_valid[r.sid]) begin
          tbl_owner[r.sid] = r.pid;
          tbl_base[r.sid]  = r.page;
          tbl_pages[r.sid] = r.count;
          tbl_valid[r.sid] = 1'b1;
          res = RSP_OK;
        end
      end
      REQ_REMOVE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i] && tbl_owner[i] == r.pid) begin
            store_busy[i] = 1'b0;
            tbl_valid[i]  = 1'b0;
            tbl_owner[i]  = '0;
            tbl_base[i]   = '0;
            tbl_pages[i]  = '0;
          end
        end
        res = RSP_OK;
      end
      default: begin
        if (r.sid < ENTRIES && !store_busy[r.sid]) begin
          store_busy[r.sid] = 1'b1;
          res = RSP_OK;
        end
      end
    endcase
    return res;
  endfunction

  // Draw a random request, steered by the table copy toward well-formed sequences:
  // mark a free store, map it, look up pages in and around its range, drop the process.
  function automatic req_beat_t draw_request();
    req_beat_t    r;
    int unsigned  sel, start, slot, off;
    bit           found;
    bit           fits;
    r.kind  = REQ_LOOKUP;
    r.pid   = ($urandom_range(9) < 8) ? PID_W'($urandom_range(3)) : PID_W'($urandom);
    r.page  = PAGE_W'($urandom);
    r.count = COUNT_W'($urandom);
    r.sid   = STORE_W'($urandom);
    sel     = $urandom_range(99);
    if (sel < 45) r.kind = REQ_LOOKUP;
    else if (sel < 70) r.kind = REQ_ADD;
    else if (sel < 88) r.kind = REQ_MARK;
    else r.kind = REQ_REMOVE;

    // find a slot that suits the request kind, starting at a random place
    start = $urandom_range(ENTRIES - 1);
    slot  = 0;
    found = 1'b0;
    for (int k = 0; k < ENTRIES; k++) begin
      case (r.kind)
        REQ_LOOKUP: fits = tbl_valid[(start + k) % ENTRIES];
        REQ_ADD:    fits = store_busy[(start + k) % ENTRIES] && !tbl_valid[(start + k) % ENTRIES];
        REQ_MARK:   fits = !store_busy[(start + k) % ENTRIES];
        default:    fits = 1'b0;
      endcase
      if (!found && fits) begin
        found = 1'b1;
        slot  = (start + k) % ENTRIES;
      end
    end

    case (r.kind)
      REQ_LOOKUP: begin
        if (found && $urandom_range(9) < 8) begin
          if ($urandom_range(9) != 0) r.pid = tbl_owner[slot];
          // the top offset lands one past the range; now and then step below it
          off    = $urandom_range(int'(tbl_pages[slot]));
          r.page = PAGE_W'(int'(tbl_base[slot]) + off - int'($urandom_range(15) == 0));
        end
      end
      REQ_ADD: begin
        if (found && $urandom_range(99) < 85) r.sid = STORE_W'(slot);
        case ($urandom_range(7))
          0:       r.count = '0;
          1:       r.count = '1;
          2, 3:    r.count = COUNT_W'($urandom);
          default: r.count = COUNT_W'($urandom_range(64, 1));
        endcase
        case ($urandom_range(3))
          0:       r.page = PAGE_W'(20'hFFFFF - $urandom_range(64));
          1:       r.page = PAGE_W'($urandom_range(200));
          default: r.page = PAGE_W'($urandom);
        endcase
      end
      REQ_MARK: begin
        if (found && $urandom_range(99) < 80) r.sid = STORE_W'(slot);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  // Monitor: sample both handshakes at the edge, predict on request beats,
  // check on response beats. Push before pop so a same-edge pair stays ordered.
  always @(posedge clk_i) begin
    req_beat_t r;
    rsp_beat_t want;
    rsp_hint_t hint;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        r.kind  = req_kind_e'(req_bus.req_type);
        r.pid   = req_bus.proc_id;
        r.page  = req_bus.page_num;
        r.count = req_bus.page_count;
        r.sid   = req_bus.store_id;
        hint    = hint_q.pop_front();
        want    = region_map_apply(r);
        // a typed-in row overrides the prediction; the table copy still advances
        pending_rsp_q.push_back(hint.fixed ? hint.rsp : want);
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_rsp_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: response beat with nothing expected, actual status %0h store %0h",
                   $time, rsp_bus.status, rsp_bus.hit_store);
        end else begin
          want = pending_rsp_q.pop_front();
          check_field("status",         32'(want.status), 32'(rsp_bus.status));
          check_field("hit_store",      32'(want.store),  32'(rsp_bus.hit_store));
          check_field("hit_base_page",  32'(want.base),   32'(rsp_bus.hit_base_page));
          check_field("hit_page_count", 32'(want.pages),  32'(rsp_bus.hit_page_count));
        end
      end
    end
  end

  // Response side: stall at random, with a chance of 7 in 100, never during the quiet stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= quiet || ($urandom_range(99) >= 7);
    end
  end

  // Request side: reset, walk the directed table, then random traffic, then drain.
  initial begin
    req_beat_t r;
    rsp_hint_t hint;
    mismatch_cnt       = 0;
    quiet              = 1'b0;
    rst_ni             = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = '0;
    req_bus.proc_id    = '0;
    req_bus.page_num   = '0;
    req_bus.page_count = '0;
    req_bus.store_id   = '0;
    rsp_bus.ready      = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i]  = 1'b0;
      store_busy[i] = 1'b0;
      tbl_owner[i]  = '0;
      tbl_base[i]   = '0;
      tbl_pages[i]  = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < DIR_N + RAND_N; n++) begin
      if (n < DIR_N) begin
        r    = DIR_TBL[n].req;
        hint = '{DIR_TBL[n].fixed, DIR_TBL[n].rsp};
      end else begin
        r    = draw_request();
        hint = '{1'b0, RSP_OK};
      end
      // hold both sides busy for a long stretch in the middle of the random part
      quiet = (n >= 250 && n < 400);
      while (!quiet && $urandom_range(99) < 7) begin
        req_bus.valid <= 1'b0;
        @(posedge clk_i);
      end
      hint_q.push_back(hint);
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= r.kind;
      req_bus.proc_id    <= r.pid;
      req_bus.page_num   <= r.page;
      req_bus.page_count <= r.count;
      req_bus.store_id   <= r.sid;
      // advance until the beat is taken
      do @(posedge clk_i); while (!req_bus.ready);
    end
    req_bus.valid <= 1'b0;
    quiet = 1'b0;

    // drain, then keep watching for stray beats before the verdict
    @(posedge clk_i);
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS backing_store_region_map_top");
    end else begin
      $display("FAIL backing_store_region_map_top");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("FAIL backing_store_region_map_top");
    $finish;
  end

endmodule

// File: sim.f
rtl/bsrm_pkg.sv
rtl/bsrm_if.sv
rtl/bsrm_ram.sv
rtl/bsrm_ctrl.sv
rtl/bsrm_dp.sv
rtl/backing_store_region_map_top.sv
rtl/bsrm_checker.sv
test/backing_store_region_map_top_tb.sv
